/* rtl/mib_statistics_counter_table_top_assert.svh */
// Assertion macros for the statistics counter table top level.
`ifndef MIB_STATISTICS_COUNTER_TABLE_TOP_ASSERT_SVH
`define MIB_STATISTICS_COUNTER_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MSCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MSCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/msct_pkg.sv */
// Shared types and constants of the statistics counter table.
package msct_pkg;

	localparam int GROUP_COUNTERS_DEF = 111;
	localparam int IFACE_COUNTERS_DEF = 13;
	localparam int INTERFACES_DEF     = 4;

	localparam int OP_W  = 3;
	localparam int ROW_W = 8;
	localparam int ID_W  = 7;
	localparam int VAL_W = 32;

	localparam int ROW_LSB = 0;
	localparam int ID_LSB  = ROW_LSB + ROW_W;
	localparam int VAL_LSB = ID_LSB + ID_W;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	// Gauge positions, following the RFC object orderings.
	localparam logic [ID_W-1:0] GROUP_GAUGE_ID = 7'd101;
	localparam logic [ID_W-1:0] IFACE_SPEED_ID = 7'd0;
	localparam logic [ID_W-1:0] IFACE_QLEN_ID  = 7'd12;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_GRP_ADD  = 3'd1,
		OP_GRP_SET  = 3'd2,
		OP_GRP_READ = 3'd3,
		OP_IF_ADD   = 3'd4,
		OP_IF_SET   = 3'd5,
		OP_IF_READ  = 3'd6
	} op_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/msct_ctrl.sv */
// Sequencing state machine of the statistics counter table.
module msct_ctrl
	import msct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CLEAR  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_next = sts.in_clear ? ST_CLEAR : ST_FINISH;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// Hold the word here until the output register has room.
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

/* rtl/msct_datapath.sv */
// Decode, counter memories, update adder and output register of the counter table.
module msct_datapath
	import msct_pkg::*;
#(
	parameter int GROUP_COUNTERS = GROUP_COUNTERS_DEF,
	parameter int IFACE_COUNTERS = IFACE_COUNTERS_DEF,
	parameter int INTERFACES     = INTERFACES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [0:0]           m_tuser
);

	localparam int GROUP_AW    = (GROUP_COUNTERS > 1) ? $clog2(GROUP_COUNTERS) : 1;
	localparam int IFACE_DEPTH = INTERFACES * IFACE_COUNTERS;
	localparam int IFACE_AW    = $clog2(IFACE_DEPTH);
	localparam int SWEEP_DEPTH = (GROUP_COUNTERS > IFACE_DEPTH) ? GROUP_COUNTERS : IFACE_DEPTH;
	localparam int SW          = $clog2(SWEEP_DEPTH);
	localparam logic [SW-1:0]       SWEEP_LAST = SW'(SWEEP_DEPTH - 1);
	localparam logic [IFACE_AW-1:0] IF_STRIDE  = IFACE_AW'(IFACE_COUNTERS);

	// Input word unpacking.
	op_t              in_op;
	logic [ROW_W-1:0] in_row;
	logic [ID_W-1:0]  in_id;
	logic [VAL_W-1:0] in_val;

	assign in_op  = op_t'(s_tuser);
	assign in_row = s_tdata[ROW_LSB +: ROW_W];
	assign in_id  = s_tdata[ID_LSB +: ID_W];
	assign in_val = s_tdata[VAL_LSB +: VAL_W];

	logic bound_q;
	logic [SW-1:0] cnt_q;

	// Range and kind checks on the incoming word.
	logic grp_ok, if_ok, grp_gauge, if_gauge;
	logic dec_done, dec_grp_we, dec_if_we, dec_add, dec_rd_grp, dec_rd_if, dec_clear;
	logic [GROUP_AW-1:0] in_grp_addr;
	logic [IFACE_AW-1:0] in_if_addr;

	assign grp_ok = bound_q && ({1'b0, in_id} < (ID_W + 1)'(GROUP_COUNTERS));
	assign if_ok  = bound_q && ({1'b0, in_row} < (ROW_W + 1)'(INTERFACES))
		&& ({1'b0, in_id} < (ID_W + 1)'(IFACE_COUNTERS));
	assign grp_gauge = (in_id == GROUP_GAUGE_ID);
	assign if_gauge  = (in_id == IFACE_SPEED_ID) || (in_id == IFACE_QLEN_ID);

	// Out-of-range indexes may alias here; such words are refused and write nothing.
	assign in_grp_addr = in_id[GROUP_AW-1:0];
	assign in_if_addr  = IFACE_AW'(in_row) * IF_STRIDE + IFACE_AW'(in_id[3:0]);

	always_comb begin
		dec_done   = 1'b0;
		dec_grp_we = 1'b0;
		dec_if_we  = 1'b0;
		dec_add    = 1'b0;
		dec_rd_grp = 1'b0;
		dec_rd_if  = 1'b0;
		dec_clear  = 1'b0;
		unique case (in_op)
			OP_CLEAR: begin
				dec_done  = 1'b1;
				dec_clear = 1'b1;
			end
			OP_GRP_ADD: begin
				dec_done   = grp_ok && !grp_gauge;
				dec_grp_we = grp_ok && !grp_gauge;
				dec_add    = 1'b1;
			end
			OP_GRP_SET: begin
				dec_done   = grp_ok && grp_gauge;
				dec_grp_we = grp_ok && grp_gauge;
			end
			OP_GRP_READ: begin
				dec_done   = grp_ok;
				dec_rd_grp = grp_ok;
			end
			OP_IF_ADD: begin
				dec_done  = if_ok && !if_gauge;
				dec_if_we = if_ok && !if_gauge;
				dec_add   = 1'b1;
			end
			OP_IF_SET: begin
				dec_done  = if_ok && if_gauge;
				dec_if_we = if_ok && if_gauge;
			end
			OP_IF_READ: begin
				dec_done  = if_ok;
				dec_rd_if = if_ok;
			end
			default: begin
			end
		endcase
	end

	// Captured word and decode results.
	logic done_s1, grp_we_s1, if_we_s1, add_s1, rd_grp_s1, rd_if_s1, clear_s1;
	logic [VAL_W-1:0]    val_s1;
	logic [GROUP_AW-1:0] grp_addr_s1;
	logic [IFACE_AW-1:0] if_addr_s1;
	logic [VAL_W-1:0]    grp_rd_s1;
	logic [VAL_W-1:0]    if_rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			done_s1     <= dec_done;
			grp_we_s1   <= dec_grp_we;
			if_we_s1    <= dec_if_we;
			add_s1      <= dec_add;
			rd_grp_s1   <= dec_rd_grp;
			rd_if_s1    <= dec_rd_if;
			clear_s1    <= dec_clear;
			val_s1      <= in_val;
			grp_addr_s1 <= in_grp_addr;
			if_addr_s1  <= in_if_addr;
		end
	end

	// Counter memories: one write port each, read data registered.
	logic [VAL_W-1:0] grp_mem [GROUP_COUNTERS];
	logic [VAL_W-1:0] if_mem  [IFACE_DEPTH];

	logic                grp_we, if_we;
	logic [GROUP_AW-1:0] grp_wa;
	logic [IFACE_AW-1:0] if_wa;
	logic [VAL_W-1:0]    grp_wd, if_wd;
	logic                cnt_in_grp, cnt_in_if;

	assign cnt_in_grp = ({1'b0, cnt_q} < (SW + 1)'(GROUP_COUNTERS));
	assign cnt_in_if  = ({1'b0, cnt_q} < (SW + 1)'(IFACE_DEPTH));

	assign grp_we = (cmd.sweep && cnt_in_grp) || (cmd.finish && grp_we_s1);
	assign if_we  = (cmd.sweep && cnt_in_if) || (cmd.finish && if_we_s1);
	assign grp_wa = cmd.sweep ? cnt_q[GROUP_AW-1:0] : grp_addr_s1;
	assign if_wa  = cmd.sweep ? cnt_q[IFACE_AW-1:0] : if_addr_s1;
	assign grp_wd = cmd.sweep ? '0 : (add_s1 ? grp_rd_s1 + val_s1 : val_s1);
	assign if_wd  = cmd.sweep ? '0 : (add_s1 ? if_rd_s1 + val_s1 : val_s1);

	always_ff @(posedge clk) begin
		if (grp_we) begin
			grp_mem[grp_wa] <= grp_wd;
		end
		if (cmd.accept) begin
			grp_rd_s1 <= grp_mem[in_grp_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (if_we) begin
			if_mem[if_wa] <= if_wd;
		end
		if (cmd.accept) begin
			if_rd_s1 <= if_mem[in_if_addr];
		end
	end

	// Sweep counter and the bound flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bound_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (cmd.sweep) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish && clear_s1) begin
				bound_q <= 1'b1;
			end
		end
	end

	// Output register.
	logic             m_valid_q;
	logic [VAL_W-1:0] m_data_q;
	logic             m_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_status_q <= !done_s1;
			m_data_q   <= rd_grp_s1 ? grp_rd_s1 : (rd_if_s1 ? if_rd_s1 : '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

	assign sts.in_clear   = (in_op == OP_CLEAR);
	assign sts.sweep_last = (cnt_q == SWEEP_LAST);
	assign sts.out_free   = !m_valid_q || m_tready;

endmodule

/* rtl/mib_statistics_counter_table_top.sv */
// Top level of the MIB-II statistics counter table.

// The block holds a flat store of GROUP_COUNTERS protocol-group statistics and a
// table of INTERFACES rows of IFACE_COUNTERS ifEntry statistics, all 32 bits wide.
// Each input word carries one operation: clear, add, set or read on either store.
// Add raises a Counter with wrap-around, set writes a Gauge and read returns either
// kind; anything but a clear issued before the first clear, with an index out of
// range, or of the wrong kind for its object is refused with status 1 and a value
// of zero, and changes nothing. Every input word yields exactly one output word.
// The block works on one word at a time: add, set and read first decode the word
// and read the counter memory into a register, then write the update and load the
// output register. A clear sweeps both memories one entry per cycle in parallel,
// covering the larger of GROUP_COUNTERS and INTERFACES * IFACE_COUNTERS entries
// (111 with the default sizes) before it finishes. Memory contents are not defined
// after reset; the first clear defines them. The result waits in an output
// register, and the finishing cycle stalls while that register is still full and
// not being taken.
module mib_statistics_counter_table_top
	import msct_pkg::*;
#(
	parameter int GROUP_COUNTERS = GROUP_COUNTERS_DEF,
	parameter int IFACE_COUNTERS = IFACE_COUNTERS_DEF,
	parameter int INTERFACES     = INTERFACES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// interface_index [7:0], counter_id [14:8], write_value [46:15], zero [47]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation [2:0]
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// read_value [31:0]
	output logic [M_TDATA_W-1:0] m_tdata,
	// status [0]
	output logic [0:0]           m_tuser
);

	`include "mib_statistics_counter_table_top_assert.svh"

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// The controller decides when a word is taken, swept or finished.
	msct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the memories, the checks and the output register.
	msct_datapath #(
		.GROUP_COUNTERS (GROUP_COUNTERS),
		.IFACE_COUNTERS (IFACE_COUNTERS),
		.INTERFACES     (INTERFACES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Only one word is in flight: after a word is taken, the input closes.
	`MSCT_ASSERT_NXT(a_single_word, s_tvalid && s_tready, !s_tready, "second word taken while busy")

	// A clear word starts the memory sweep in the following cycle.
	`MSCT_ASSERT_NXT(a_clear_sweeps, s_tvalid && s_tready && (s_tuser == OP_CLEAR), cmd.sweep, "clear did not start the sweep")

	// A refused word never carries a value.
	`MSCT_ASSERT_IMP(a_refused_zero, m_tvalid && m_tuser[0], m_tdata == '0, "refused word with a non-zero value")

endmodule

/* bench/msct_tb_pkg.sv */
// Scoreboard for the statistics counter table: a predictor of both stores and a store of expected results.
package msct_tb_pkg;
	import msct_pkg::*;

	// Operation code seven is not in op_t; the block must refuse it.
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int ROW_ENTRIES = INTERFACES_DEF * IFACE_COUNTERS_DEF;

	typedef struct packed {
		logic             refused;
		logic [VAL_W-1:0] value;
	} outcome_t;

	class counter_table_scoreboard;
		logic [VAL_W-1:0] group_image [GROUP_COUNTERS_DEF];
		logic [VAL_W-1:0] row_image [ROW_ENTRIES];
		bit               bound;
		outcome_t         awaited [$];
		int unsigned      faults;
		int unsigned      refusals;
		int unsigned      checked;

		function new();
			bound    = 1'b0;
			faults   = 0;
			refusals = 0;
			checked  = 0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Applies one accepted word to the image of the stores and queues its outcome.
		function void note_word(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
				logic [ID_W-1:0] id, logic [VAL_W-1:0] val);
			outcome_t res;
			bit       group_ok;
			bit       row_ok;
			bit       row_gauge;
			int       at;
			res.refused = 1'b1;
			res.value   = '0;
			group_ok    = bound && (int'(id) < GROUP_COUNTERS_DEF);
			row_ok      = bound && (int'(row) < INTERFACES_DEF) && (int'(id) < IFACE_COUNTERS_DEF);
			row_gauge   = (id == IFACE_SPEED_ID) || (id == IFACE_QLEN_ID);
			at          = row_ok ? int'(row) * IFACE_COUNTERS_DEF + int'(id) : 0;
			case (op)
				OP_CLEAR: begin
					foreach (group_image[i]) group_image[i] = '0;
					foreach (row_image[i]) row_image[i] = '0;
					bound       = 1'b1;
					res.refused = 1'b0;
				end
				OP_GRP_ADD: begin
					if (group_ok && id != GROUP_GAUGE_ID) begin
						group_image[id] = group_image[id] + val;
						res.refused     = 1'b0;
					end
				end
				OP_GRP_SET: begin
					if (group_ok && id == GROUP_GAUGE_ID) begin
						group_image[id] = val;
						res.refused     = 1'b0;
					end
				end
				OP_GRP_READ: begin
					if (group_ok) begin
						res.value   = group_image[id];
						res.refused = 1'b0;
					end
				end
				OP_IF_ADD: begin
					if (row_ok && !row_gauge) begin
						row_image[at] = row_image[at] + val;
						res.refused   = 1'b0;
					end
				end
				OP_IF_SET: begin
					if (row_ok && row_gauge) begin
						row_image[at] = val;
						res.refused   = 1'b0;
					end
				end
				OP_IF_READ: begin
					if (row_ok) begin
						res.value   = row_image[at];
						res.refused = 1'b0;
					end
				end
				default: begin
				end
			endcase
			awaited.push_back(res);
		endfunction

		// Compares one result word with the oldest outcome still awaited.
		function void check_word(logic refused, logic [VAL_W-1:0] value);
			outcome_t exp;
			checked++;
			if (refused === 1'b1)
				refusals++;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing awaited: status %0d, value 0x%08h",
					$time, refused, value);
				faults++;
				return;
			end
			exp = awaited.pop_front();
			if (refused !== exp.refused) begin
				$display("%0t: status expected %0d, got %0d", $time, exp.refused, refused);
				faults++;
			end
			if (value !== exp.value) begin
				$display("%0t: read value expected 0x%08h, got 0x%08h", $time, exp.value, value);
				faults++;
			end
		endfunction
	endclass

endpackage

/* bench/tb_top.sv */
// Top-level testbench of the statistics counter table: stimulus, handshakes and the final verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msct_pkg::*;
	import msct_tb_pkg::*;

	// Number of random words after the directed opening; the directed part adds about 30.
	localparam int RANDOM_WORDS = 1675;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [OP_W-1:0]      s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;

	// While set, neither side inserts idle cycles.
	bit                      steady = 1'b0;
	int unsigned             words_sent [8];
	counter_table_scoreboard sb = new();

	mib_statistics_counter_table_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiving side stalls in roughly a quarter of the cycles, except in the steady stretch.
	always @(posedge clk) begin
		if (steady)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 24);
	end

	// Every result word taken from the block is checked against the oldest expectation.
	// Values are sampled at the edge before any of the block's updates land.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser[0], m_tdata);
	end

	// Offers one word, possibly after a short idle gap, and notes it once accepted.
	// tdata carries interface_index, counter_id and write_value from the lowest bit up,
	// with a zero pad bit on top; tuser carries the operation.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
			input logic [ID_W-1:0] id, input logic [VAL_W-1:0] val);
		if (!steady && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, val, id, row};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, row, id, val);
		words_sent[op]++;
	endtask

	// Withdraws the last offered word and holds off until every expected result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed operations on indices in range, with some out-of-range noise,
	// wrong-kind requests, the unused code and the odd clear.
	task automatic send_random_word();
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] row;
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] val;
		int unsigned      pick;
		pick = $urandom_range(99);
		if (pick < 1)
			op = OP_CLEAR;
		else if (pick < 3)
			op = OP_UNUSED;
		else if (pick < 18)
			op = OP_GRP_ADD;
		else if (pick < 26)
			op = OP_GRP_SET;
		else if (pick < 44)
			op = OP_GRP_READ;
		else if (pick < 62)
			op = OP_IF_ADD;
		else if (pick < 70)
			op = OP_IF_SET;
		else
			op = OP_IF_READ;

		if ($urandom_range(99) < 80)
			row = ROW_W'($urandom_range(INTERFACES_DEF - 1));
		else
			row = ROW_W'($urandom);

		if ($urandom_range(99) < 15)
			id = ID_W'($urandom);
		else if (op == OP_GRP_SET && $urandom_range(99) < 75)
			id = GROUP_GAUGE_ID;
		else if (op == OP_IF_SET && $urandom_range(99) < 75)
			id = $urandom_range(1) ? IFACE_QLEN_ID : IFACE_SPEED_ID;
		else if (op == OP_IF_ADD || op == OP_IF_SET || op == OP_IF_READ)
			id = ID_W'($urandom_range(IFACE_COUNTERS_DEF - 1));
		else
			id = ID_W'($urandom_range(GROUP_COUNTERS_DEF - 1));

		pick = $urandom_range(99);
		if (pick < 15)
			val = '1;
		else if (pick < 25)
			val = '0;
		else if (pick < 35)
			val = VAL_W'(1);
		else
			val = VAL_W'($urandom);

		send_word(op, row, id, val);
	endtask

	initial begin : stimulus
		int unsigned n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before the first clear the store is unbound, so everything but clear is refused.
		send_word(OP_GRP_READ, 8'd0, 7'd0, 32'd0);
		send_word(OP_IF_ADD, 8'd0, 7'd1, 32'd1);
		send_word(OP_GRP_SET, 8'd0, GROUP_GAUGE_ID, 32'hFFFF_FFFF);
		send_word(OP_CLEAR, 8'd0, 7'd0, 32'd0);

		// A counter wraps past 2^32; the group gauge takes a set and refuses an add.
		send_word(OP_GRP_ADD, 8'd0, 7'd0, 32'hFFFF_FFFF);
		send_word(OP_GRP_ADD, 8'd0, 7'd0, 32'd2);
		send_word(OP_GRP_READ, 8'd0, 7'd0, 32'd0);
		send_word(OP_GRP_SET, 8'd0, GROUP_GAUGE_ID, 32'hFFFF_FFFF);
		send_word(OP_GRP_READ, 8'd0, GROUP_GAUGE_ID, 32'd0);
		send_word(OP_GRP_SET, 8'd0, 7'd5, 32'd7);
		send_word(OP_GRP_ADD, 8'd0, GROUP_GAUGE_ID, 32'd1);
		send_word(OP_GRP_ADD, 8'd0, 7'd110, 32'h8000_0000);
		send_word(OP_GRP_READ, 8'd0, 7'd110, 32'd0);
		send_word(OP_GRP_READ, 8'd0, 7'd111, 32'd0);
		send_word(OP_GRP_ADD, 8'hFF, 7'd127, 32'hFFFF_FFFF);

		// Interface rows: both gauges, a counter in the last row, and every range refusal.
		send_word(OP_IF_ADD, 8'd3, 7'd11, 32'hFFFF_FFFF);
		send_word(OP_IF_ADD, 8'd3, 7'd11, 32'h1234_5678);
		send_word(OP_IF_SET, 8'd0, IFACE_SPEED_ID, 32'hAAAA_AAAA);
		send_word(OP_IF_SET, 8'd3, IFACE_QLEN_ID, 32'h5555_5555);
		send_word(OP_IF_ADD, 8'd0, IFACE_QLEN_ID, 32'd1);
		send_word(OP_IF_SET, 8'd1, 7'd5, 32'd9);
		send_word(OP_IF_READ, 8'd3, 7'd11, 32'd0);
		send_word(OP_IF_READ, 8'd0, IFACE_SPEED_ID, 32'd0);
		send_word(OP_IF_READ, 8'd4, 7'd1, 32'd0);
		send_word(OP_IF_READ, 8'hFF, 7'd127, 32'd0);
		send_word(OP_IF_ADD, 8'd2, 7'd13, 32'd1);
		send_word(OP_UNUSED, 8'd0, 7'd0, 32'hFFFF_FFFF);

		// A second clear must zero what was written above.
		send_word(OP_CLEAR, 8'd0, 7'd0, 32'd0);
		send_word(OP_GRP_READ, 8'd0, 7'd0, 32'd0);
		send_word(OP_IF_READ, 8'd3, IFACE_QLEN_ID, 32'd0);
		drain_results();

		for (n = 0; n < RANDOM_WORDS; n++) begin
			steady = (n >= 700 && n < 1000);
			// Once mid-run the sender waits for the block to empty completely.
			if (n == 400)
				drain_results();
			send_random_word();
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		// Every word yields exactly one result, so the run can end once the last one has been taken.
		drain_results();
		repeat (8) @(posedge clk);

		$display("Run covered %0d clears, %0d group and %0d interface operations, %0d unused codes.",
			words_sent[OP_CLEAR],
			words_sent[OP_GRP_ADD] + words_sent[OP_GRP_SET] + words_sent[OP_GRP_READ],
			words_sent[OP_IF_ADD] + words_sent[OP_IF_SET] + words_sent[OP_IF_READ],
			words_sent[OP_UNUSED]);
		$display("%0d result words checked, %0d of them refusals.", sb.checked, sb.refusals);
		if (sb.faults == 0 && sb.outstanding() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Well beyond the slowest correct run, even with a full sweep for every word.
	initial begin
		#20ms;
		$display("tb_top failed");
		$finish;
	end

endmodule
